// ===== sv/sorted_array_map_defines.svh =====
// Assertion macros for the sorted array map.
`ifndef SORTED_ARRAY_MAP_DEFINES_SVH
`define SORTED_ARRAY_MAP_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define SAM_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted_array_map: check failed");
// Check a property on every clock edge, reset included.
`define SAM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sorted_array_map: check failed");
`else
`define SAM_ASSERT(name, prop)
`define SAM_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== sv/sam_pkg.sv =====
package sam_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  // request codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_GETINS = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // result codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } sam_cmd_t;

endpackage

// ===== sv/sam_datapath.sv =====
module sam_datapath #(
  parameter int CAPACITY = sam_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sam_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sam_pkg::sam_cmd_t    cmd,
  input  logic [2:0]           opcode,
  input  logic [KEY_BITS-1:0]  req_key,
  input  logic [31:0]          req_weight,
  input  logic [15:0]          req_age,
  output logic [1:0]           status,
  output logic                 hit,
  output logic [31:0]          out_weight,
  output logic [15:0]          out_age,
  output logic [CNT_W-1:0]     count
);
  import sam_pkg::*;

  // registered request
  logic [2:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0]         weight_r;
  logic [15:0]         age_r;

  // entry cells, held in descending key order
  logic [KEY_BITS-1:0] key_cell    [CAPACITY];
  logic [31:0]         weight_cell [CAPACITY];
  logic [15:0]         age_cell    [CAPACITY];
  logic [KEY_BITS-1:0] key_nx      [CAPACITY];
  logic [31:0]         weight_nx   [CAPACITY];
  logic [15:0]         age_nx      [CAPACITY];

  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    entry_count_next;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] ahead;
  logic [CAPACITY-1:0] match;

  logic        found;
  logic        full;
  logic        do_ins;
  logic        do_ers;
  logic [31:0] ins_weight;
  logic [15:0] ins_age;
  logic [31:0] sel_weight;
  logic [15:0] sel_age;
  logic [1:0]  status_next;
  logic        hit_next;
  logic [31:0] weight_next;
  logic [15:0] age_next;

  // latch the request on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= opcode;
      key_r    <= req_key;
      weight_r <= req_weight;
      age_r    <= req_age;
    end
  end

  // compare every live cell against the key in parallel
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    assign valid[g] = CNT_W'(g) < entry_count;
    assign ahead[g] = valid[g] && (key_cell[g] > key_r);
    assign match[g] = valid[g] && (key_cell[g] == key_r);
  end

  assign found      = |match;
  assign full       = entry_count == CNT_W'(CAPACITY);
  assign do_ins     = ((op_r == OP_INSERT) || (op_r == OP_GETINS)) && !found && !full;
  assign do_ers     = (op_r == OP_ERASE) && found;
  assign ins_weight = (op_r == OP_INSERT) ? weight_r : 32'd0;
  assign ins_age    = (op_r == OP_INSERT) ? age_r : 16'd0;

  // pick the value of the matching cell
  always_comb begin
    sel_weight = '0;
    sel_age    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        sel_weight = sel_weight | weight_cell[i];
        sel_age    = sel_age | age_cell[i];
      end
    end
  end

  // shift cells down on insert, up on erase
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      key_nx[g]    = key_cell[g];
      weight_nx[g] = weight_cell[g];
      age_nx[g]    = age_cell[g];
      if (do_ins) begin
        if (!ahead[g]) begin
          if (g == 0) begin
            key_nx[g]    = key_r;
            weight_nx[g] = ins_weight;
            age_nx[g]    = ins_age;
          end else if (ahead[(g == 0) ? 0 : g - 1]) begin
            key_nx[g]    = key_r;
            weight_nx[g] = ins_weight;
            age_nx[g]    = ins_age;
          end else begin
            key_nx[g]    = key_cell[(g == 0) ? 0 : g - 1];
            weight_nx[g] = weight_cell[(g == 0) ? 0 : g - 1];
            age_nx[g]    = age_cell[(g == 0) ? 0 : g - 1];
          end
        end
      end else if (g < CAPACITY - 1) begin
        if (!ahead[g]) begin
          key_nx[g]    = key_cell[(g < CAPACITY - 1) ? g + 1 : g];
          weight_nx[g] = weight_cell[(g < CAPACITY - 1) ? g + 1 : g];
          age_nx[g]    = age_cell[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec && (do_ins || do_ers)) begin
        key_cell[g]    <= key_nx[g];
        weight_cell[g] <= weight_nx[g];
        age_cell[g]    <= age_nx[g];
      end
    end
  end

  // form the result and the new count
  always_comb begin
    status_next      = STAT_OK;
    hit_next         = 1'b0;
    weight_next      = '0;
    age_next         = '0;
    entry_count_next = entry_count;
    case (op_r)
      OP_INSERT: begin
        if (found) begin
          status_next = STAT_PRESENT;
          hit_next    = 1'b1;
          weight_next = sel_weight;
          age_next    = sel_age;
        end else if (full) begin
          status_next = STAT_FULL;
        end else begin
          weight_next      = weight_r;
          age_next         = age_r;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (found) begin
          hit_next         = 1'b1;
          weight_next      = sel_weight;
          age_next         = sel_age;
          entry_count_next = entry_count - CNT_W'(1);
        end else begin
          status_next = STAT_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          hit_next    = 1'b1;
          weight_next = sel_weight;
          age_next    = sel_age;
        end else begin
          status_next = STAT_MISSING;
        end
      end
      OP_GETINS: begin
        if (found) begin
          hit_next    = 1'b1;
          weight_next = sel_weight;
          age_next    = sel_age;
        end else if (full) begin
          status_next = STAT_FULL;
        end else begin
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
        entry_count_next = entry_count;
      end
    endcase
  end

  // hold the count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.exec) begin
      entry_count <= entry_count_next;
    end
  end

  // hold the result for the strobe cycle
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= status_next;
      hit        <= hit_next;
      out_weight <= weight_next;
      out_age    <= age_next;
    end
  end

  assign count = entry_count;

endmodule

// ===== sv/sam_ctrl.sv =====
module sam_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output sam_pkg::sam_cmd_t cmd
);
  import sam_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // advance from accept to execute and back
  always_comb begin
    case (state)
      ST_IDLE: state_next = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  assign busy     = (state == ST_EXEC);
  assign cmd.load = start && (state == ST_IDLE);
  assign cmd.exec = (state == ST_EXEC);

endmodule

// ===== sv/sorted_array_map.sv =====
// Sorted array map: one request in, one result out.
// The accepting edge moves the controller into its execute state; the edge that ends
// that state registers the result and raises done.
// A new request is accepted only while idle, not while busy in the execute state,
// in which all cells compare against the key and shift together.
// Reset (rst, synchronous): empties the table; cell contents are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
`include "sorted_array_map_defines.svh"

module sorted_array_map #(
  parameter int CAPACITY = sam_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sam_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          opcode,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [31:0]         req_weight,
  input  logic [15:0]         req_age,
  output logic                done,
  output logic [1:0]          status,
  output logic                hit,
  output logic [31:0]         out_weight,
  output logic [15:0]         out_age,
  output logic [CNT_W-1:0]    count
);
  import sam_pkg::*;

  sam_cmd_t cmd;

  sam_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  sam_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .req_key    (req_key),
    .req_weight (req_weight),
    .req_age    (req_age),
    .status     (status),
    .hit        (hit),
    .out_weight (out_weight),
    .out_age    (out_age),
    .count      (count)
  );

  `SAM_ASSERT(a_accept_then_busy, start && !busy |=> busy)
  `SAM_ASSERT(a_busy_then_done, busy |=> done && !busy)
  `SAM_ASSERT(a_done_after_busy, done |-> $past(busy))
  `SAM_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))
  `SAM_ASSERT_ALWAYS(a_reset_empties, rst |=> count == '0 && !done)

endmodule

// ===== sim/tb_sorted_array_map.sv =====
`timescale 1ns / 1ps

module tb_sorted_array_map;
  import sam_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int KEY_W       = KEY_BITS_DEF;
  localparam int POOL_SIZE   = 96;
  localparam int PHASE_ITEMS = 216;
  localparam int NUM_PHASES  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 8;
  localparam int FULL_DWELL  = 12;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] weight;
    logic [15:0] age;
    logic [6:0]  count;
  } map_reply_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [KEY_W-1:0] key;
    logic [31:0]      weight;
    logic [15:0]      age;
    logic             typed;
    map_reply_t       reply;
  } stim_row_t;

  logic             clk;
  logic             rst        = 1'b1;
  logic             start      = 1'b0;
  logic [2:0]       opcode     = OP_LOOKUP;
  logic [KEY_W-1:0] req_key    = '0;
  logic [31:0]      req_weight = '0;
  logic [15:0]      req_age    = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic             hit;
  logic [31:0]      out_weight;
  logic [15:0]      out_age;
  logic [6:0]       count;

  // mirror of the table contents, descending key order
  logic [KEY_W-1:0] map_keys    [CAP];
  logic [31:0]      map_weights [CAP];
  logic [15:0]      map_ages    [CAP];
  int               map_count = 0;

  map_reply_t       reply_queue [$];
  stim_row_t        rows [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               fail_count  = 0;
  int               cycle_count = 0;
  int               gap_pct     = 0;

  sorted_array_map u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .req_key    (req_key),
    .req_weight (req_weight),
    .req_age    (req_age),
    .done       (done),
    .status     (status),
    .hit        (hit),
    .out_weight (out_weight),
    .out_age    (out_age),
    .count      (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one request to the mirrored table and return its reply
  function automatic map_reply_t map_apply(input logic [2:0] op, input logic [KEY_W-1:0] key,
                                           input logic [31:0] w, input logic [15:0] a);
    map_reply_t r;
    int         idx;
    int         pos;
    bit         found;
    r = '0;
    r.status = STAT_OK;
    idx = map_count;
    for (int i = 0; i < map_count; i++)
      if (idx == map_count && map_keys[i] == key) idx = i;
    found = idx < map_count;
    case (op)
      OP_INSERT, OP_GETINS: begin
        if (found) begin
          r.hit    = 1'b1;
          r.weight = map_weights[idx];
          r.age    = map_ages[idx];
          r.status = (op == OP_INSERT) ? STAT_PRESENT : STAT_OK;
        end else if (map_count >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          // find the first smaller key, shift the tail down
          pos = map_count;
          for (int i = map_count - 1; i >= 0; i--)
            if (key > map_keys[i]) pos = i;
          for (int i = map_count; i > pos; i--) begin
            map_keys[i]    = map_keys[i-1];
            map_weights[i] = map_weights[i-1];
            map_ages[i]    = map_ages[i-1];
          end
          map_keys[pos]    = key;
          map_weights[pos] = (op == OP_INSERT) ? w : '0;
          map_ages[pos]    = (op == OP_INSERT) ? a : '0;
          map_count++;
          if (op == OP_INSERT) begin
            r.weight = w;
            r.age    = a;
          end
        end
      end
      OP_ERASE: begin
        if (found) begin
          r.hit    = 1'b1;
          r.weight = map_weights[idx];
          r.age    = map_ages[idx];
          for (int i = idx; i + 1 < map_count; i++) begin
            map_keys[i]    = map_keys[i+1];
            map_weights[i] = map_weights[i+1];
            map_ages[i]    = map_ages[i+1];
          end
          map_count--;
        end else begin
          r.status = STAT_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          r.hit    = 1'b1;
          r.weight = map_weights[idx];
          r.age    = map_ages[idx];
        end else begin
          r.status = STAT_MISSING;
        end
      end
      OP_CLEAR: map_count = 0;
      default: ;
    endcase
    r.count = map_count[6:0];
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [2:0] op, input logic [KEY_W-1:0] key,
                                       input logic [31:0] w, input logic [15:0] a,
                                       input logic typed, input logic [1:0] st,
                                       input logic h, input logic [31:0] rw,
                                       input logic [15:0] ra, input logic [6:0] cnt);
    stim_row_t row;
    row.op           = op;
    row.key          = key;
    row.weight       = w;
    row.age          = a;
    row.typed        = typed;
    row.reply.status = st;
    row.reply.hit    = h;
    row.reply.weight = rw;
    row.reply.age    = ra;
    row.reply.count  = cnt;
    return row;
  endfunction

  function automatic void note_fail(input string what, input map_reply_t want,
                                    input map_reply_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: want st=%0d hit=%0d w=%h age=%h cnt=%0d, got st=%0d hit=%0d w=%h age=%h cnt=%0d",
               what, want.status, want.hit, want.weight, want.age, want.count,
               got.status, got.hit, got.weight, got.age, got.count);
  endfunction

  // drive one item from the falling edge and hold it until accepted
  task automatic send(input logic [2:0] op, input logic [KEY_W-1:0] key, input logic [31:0] w,
                      input logic [15:0] a, input logic typed, input map_reply_t typed_reply);
    map_reply_t pred;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    req_key    <= key;
    req_weight <= w;
    req_age    <= a;
    do @(posedge clk); while (busy);
    pred = map_apply(op, key, w, a);
    reply_queue.push_back(typed ? typed_reply : pred);
  endtask

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom();
  endfunction

  // favor live keys when asked, else the shared pool, sometimes a fresh key
  function automatic logic [KEY_W-1:0] pick_key(input int live_pct);
    int r;
    r = $urandom_range(99);
    if (map_count > 0 && r < live_pct) return map_keys[$urandom_range(map_count - 1)];
    if (r < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // check each result against the oldest pending reply; stop on timeout
  always @(posedge clk) begin
    map_reply_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst && done) begin
      got = {status, hit, out_weight, out_age, count};
      if (reply_queue.size() == 0) begin
        note_fail("unexpected result", '0, got);
      end else begin
        if (got !== reply_queue[0]) note_fail("mismatch", reply_queue[0], got);
        void'(reply_queue.pop_front());
      end
    end
  end

  initial begin
    logic [2:0]       op;
    logic [KEY_W-1:0] key;
    bit               grow;
    int               full_items;
    int               r;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h7FFF_FFFF;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    // directed rows: empty table, extremes, duplicates, gaps, unused codes, clear
    rows.push_back(mk_row(OP_LOOKUP, 32'h0000_0000, '0, '0, 1, STAT_MISSING, 0, '0, '0, 0));
    rows.push_back(mk_row(OP_ERASE, 32'hFFFF_FFFF, '0, '0, 1, STAT_MISSING, 0, '0, '0, 0));
    rows.push_back(mk_row(OP_GETINS, 32'h1234_5678, '1, '1, 1, STAT_OK, 0, '0, '0, 1));
    rows.push_back(mk_row(OP_INSERT, 32'hFFFF_FFFF, '1, '1, 1, STAT_OK, 0, '1, '1, 2));
    rows.push_back(mk_row(OP_INSERT, 32'h0000_0000, '0, '0, 1, STAT_OK, 0, '0, '0, 3));
    rows.push_back(mk_row(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 16'h5A5A, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_INSERT, 32'hFFFF_FFFF, 32'h1, 16'h1, 1, STAT_PRESENT, 1, '1, '1, 4));
    rows.push_back(mk_row(OP_LOOKUP, 32'h8000_0000, '0, '0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_GETINS, 32'h1234_5678, '1, '1, 1, STAT_OK, 1, '0, '0, 4));
    rows.push_back(mk_row(OP_GETINS, 32'h7FFF_FFFF, '1, '1, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ERASE, 32'hFFFF_FFFF, '0, '0, 1, STAT_OK, 1, '1, '1, 4));
    rows.push_back(mk_row(OP_ERASE, 32'h0000_0000, '0, '0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_ERASE, 32'h0000_0000, '0, '0, 1, STAT_MISSING, 0, '0, '0, 3));
    rows.push_back(mk_row(OP_UNUSED_LO, 32'h8000_0000, '1, '1, 1, STAT_OK, 0, '0, '0, 3));
    rows.push_back(mk_row(OP_UNUSED_LO + 3'd1, 32'h8000_0000, '1, '1, 1, STAT_OK, 0, '0, '0, 3));
    rows.push_back(mk_row(OP_UNUSED_HI, 32'h8000_0000, '1, '1, 1, STAT_OK, 0, '0, '0, 3));
    rows.push_back(mk_row(OP_LOOKUP, 32'h8000_0000, '0, '0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_INSERT, 32'h0000_0001, 32'h1, 16'h1, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(OP_CLEAR, '1, '1, '1, 1, STAT_OK, 0, '0, '0, 0));
    rows.push_back(mk_row(OP_LOOKUP, 32'h8000_0000, '0, '0, 1, STAT_MISSING, 0, '0, '0, 0));
    rows.push_back(mk_row(OP_INSERT, 32'h8000_0000, 32'h0F0F_F0F0, 16'hC33C, 0, 0, 0, 0, 0, 0));

    // hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct = 23;
    foreach (rows[i])
      send(rows[i].op, rows[i].key, rows[i].weight, rows[i].age, rows[i].typed, rows[i].reply);

    // random part: fill to capacity, dwell at full, drain, repeat
    grow       = 1'b1;
    full_items = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: gap_pct = 0;
        1: gap_pct = 77;
        2: gap_pct = 0;
        default: gap_pct = 23;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (grow) begin
          if (r < 45)      op = OP_INSERT;
          else if (r < 65) op = OP_GETINS;
          else if (r < 82) op = OP_LOOKUP;
          else if (r < 93) op = OP_ERASE;
          else if (r < 94) op = OP_CLEAR;
          else             op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        end else begin
          if (r < 50)      op = OP_ERASE;
          else if (r < 62) op = OP_INSERT;
          else if (r < 80) op = OP_LOOKUP;
          else if (r < 90) op = OP_GETINS;
          else if (r < 91) op = OP_CLEAR;
          else             op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        end
        key = pick_key((op == OP_ERASE || op == OP_LOOKUP) ? 70 : 10);
        send(op, key, pick_word(), 16'(pick_word()), 1'b0, '0);
        // switch between filling and draining
        if (map_count == CAP) full_items++;
        if (grow && full_items > FULL_DWELL) begin
          grow       = 1'b0;
          full_items = 0;
        end else if (!grow && map_count <= 4) begin
          grow = 1'b1;
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sam_pkg.sv
sv/sam_datapath.sv
sv/sam_ctrl.sv
sv/sorted_array_map.sv
sim/tb_sorted_array_map.sv
